@@ src/smpd_pkg.sv @@
// Shared constants and types for the slope-matching period detector.
`default_nettype none
package smpd_pkg;

  localparam int DEF_WINDOW_DEPTH  = 16;
  localparam int DEF_INTERVAL_BITS = 16;

  localparam int PERIOD_W   = 20;
  localparam int SLOPE_W    = 8;
  localparam int ITOL_W     = 16;
  localparam int STOL_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CODE_W     = 2;
  localparam int CLASS_W    = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

  localparam logic [ITOL_W-1:0] ITOL_RESET = 16'd10;
  localparam logic [STOL_W-1:0] STOL_RESET = 8'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TOL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_TOL    = 1'd1;

  // input kinds
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_ABOVE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_WITHIN = 2'd1;

  // result codes
  localparam logic [CODE_W-1:0] RES_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] RES_INIT  = 2'd1;
  localparam logic [CODE_W-1:0] RES_FOUND = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [PERIOD_W-1:0] period;
    logic                pin;
    logic                det_rst;
  } smpd_result_t;

endpackage
`default_nettype wire

@@ src/smpd_window_ram.sv @@
// Window store: interval and slope per entry, one write and one registered read a cycle.
`default_nettype none
module smpd_window_ram #(
  parameter int DEPTH  = smpd_pkg::DEF_WINDOW_DEPTH,
  parameter int DATA_W = smpd_pkg::DEF_INTERVAL_BITS + smpd_pkg::SLOPE_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/smpd_ctrl.sv @@
// Sequencer: decodes items, keeps counters, matches against entry 0 and sums the window.
`default_nettype none
module smpd_ctrl #(
  parameter int WINDOW_DEPTH  = smpd_pkg::DEF_WINDOW_DEPTH,
  parameter int INTERVAL_BITS = smpd_pkg::DEF_INTERVAL_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [2:0]                            in_tuser,
  input  wire logic [7:0]                            in_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [smpd_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire logic [smpd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                       mem_wr_en,
  output logic [$clog2(WINDOW_DEPTH)-1:0]            mem_wr_addr,
  output logic [INTERVAL_BITS+smpd_pkg::SLOPE_W-1:0] mem_wr_data,
  output logic                                       mem_rd_en,
  output logic [$clog2(WINDOW_DEPTH)-1:0]            mem_rd_addr,
  input  wire logic [INTERVAL_BITS+smpd_pkg::SLOPE_W-1:0] mem_rd_data,
  input  wire logic                                  buf_free,
  output logic                                       res_valid,
  output smpd_pkg::smpd_result_t                     res
);
  import smpd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (INTERVAL_BITS > ITOL_W) ? INTERVAL_BITS : ITOL_W;
  localparam int ACC_W = ((INTERVAL_BITS > PERIOD_W) ? INTERVAL_BITS : PERIOD_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         fill_r, fill_nxt;
  logic [IDX_W-1:0]         miss_r, miss_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [INTERVAL_BITS-1:0] tick_r, tick_nxt;
  logic [PERIOD_W-1:0]      period_r, period_nxt;
  logic [PERIOD_W-1:0]      acc_r, acc_nxt;
  logic [INTERVAL_BITS-1:0] cur_int_r, cur_int_nxt;
  logic [SLOPE_W-1:0]       cur_slope_r, cur_slope_nxt;
  logic [ITOL_W-1:0]        itol_r;
  logic [STOL_W-1:0]        stol_r;

  logic                     in_fire;
  logic                     mode;
  logic [CLASS_W-1:0]       cls;
  logic [INTERVAL_BITS-1:0] e0_int, e_int, d_int;
  logic [SLOPE_W-1:0]       e0_slope, d_slope;
  logic                     is_match;
  logic                     fill_full, miss_full;
  logic [ACC_W-1:0]         acc_sum;
  logic [PERIOD_W-1:0]      acc_sat;
  logic                     last_idx;

  assign in_tready = (state_r == ST_IDLE) && buf_free;
  assign in_fire   = in_tvalid && in_tready;
  assign mode      = in_tuser[0];
  assign cls       = in_tuser[2:1];

  assign e0_int   = mem_rd_data[INTERVAL_BITS+SLOPE_W-1:SLOPE_W];
  assign e0_slope = mem_rd_data[SLOPE_W-1:0];
  assign e_int    = e0_int;

  assign d_int    = (e0_int >= cur_int_r) ? (e0_int - cur_int_r) : (cur_int_r - e0_int);
  assign d_slope  = (e0_slope >= cur_slope_r) ? (e0_slope - cur_slope_r)
                                              : (cur_slope_r - e0_slope);
  assign is_match = (CMP_W'(d_int) <= CMP_W'(itol_r)) && (d_slope <= stol_r);

  assign fill_full = (CNT_W'(fill_r) + CNT_W'(1)) == CNT_W'(WINDOW_DEPTH);
  assign miss_full = (CNT_W'(miss_r) + CNT_W'(1)) == CNT_W'(WINDOW_DEPTH);
  assign last_idx  = idx_r == (fill_r - IDX_W'(1));

  // running sum with saturation; in compare state the sum starts from zero
  assign acc_sum = ((state_r == ST_SUM) ? ACC_W'(acc_r) : ACC_W'(0)) + ACC_W'(e_int);
  assign acc_sat = (acc_sum > ACC_W'(PERIOD_MAX)) ? PERIOD_MAX : acc_sum[PERIOD_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    miss_nxt      = miss_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    period_nxt    = period_r;
    acc_nxt       = acc_r;
    cur_int_nxt   = cur_int_r;
    cur_slope_nxt = cur_slope_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = fill_r;
    mem_wr_data   = {tick_r, in_tdata};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    res_valid     = 1'b0;
    res.code      = RES_NONE;
    res.pin       = 1'b0;
    res.det_rst   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_valid = 1'b1;
          if (mode == MODE_TICK) begin
            if (tick_r != {INTERVAL_BITS{1'b1}}) begin
              tick_nxt = tick_r + INTERVAL_BITS'(1);
            end
          end else if (cls == CLS_ABOVE) begin
            miss_nxt = '0;
            tick_nxt = '0;
            fill_nxt = '0;
            res.pin  = 1'b1;
          end else if (cls == CLS_WITHIN) begin
            mem_wr_en     = 1'b1;
            tick_nxt      = '0;
            cur_int_nxt   = tick_r;
            cur_slope_nxt = in_tdata;
            if (fill_r == '0) begin
              miss_nxt = '0;
              fill_nxt = IDX_W'(1);
              res.code = RES_INIT;
            end else begin
              res_valid = 1'b0;
              mem_rd_en = 1'b1;
              state_nxt = ST_CMP;
            end
          end else begin
            if (miss_full) begin
              fill_nxt    = '0;
              tick_nxt    = '0;
              miss_nxt    = '0;
              res.det_rst = 1'b1;
            end else begin
              miss_nxt = miss_r + IDX_W'(1);
            end
          end
        end
      end
      ST_CMP: begin
        if (is_match) begin
          acc_nxt = acc_sat;
          if (fill_r == IDX_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt     = IDX_W'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = IDX_W'(1);
            state_nxt   = ST_SUM;
          end
        end else begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          if (fill_full) begin
            fill_nxt    = '0;
            tick_nxt    = '0;
            miss_nxt    = '0;
            res.det_rst = 1'b1;
          end else begin
            fill_nxt = fill_r + IDX_W'(1);
          end
        end
      end
      ST_SUM: begin
        acc_nxt = acc_sat;
        if (last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt     = idx_r + IDX_W'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // period found: move the matching entry to slot 0
    if ((state_r == ST_CMP && is_match && fill_r == IDX_W'(1)) ||
        (state_r == ST_SUM && last_idx)) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = '0;
      mem_wr_data = {cur_int_r, cur_slope_r};
      period_nxt  = acc_sat;
      fill_nxt    = IDX_W'(1);
      miss_nxt    = '0;
      res_valid   = 1'b1;
      res.code    = RES_FOUND;
      res.pin     = 1'b1;
    end

    res.period = period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      miss_r   <= '0;
      tick_r   <= '0;
      period_r <= '0;
      itol_r   <= ITOL_RESET;
      stol_r   <= STOL_RESET;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      miss_r   <= miss_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
      if (cfg_we && cfg_addr == REG_INTERVAL_TOL) begin
        itol_r <= cfg_wdata[ITOL_W-1:0];
      end
      if (cfg_we && cfg_addr == REG_SLOPE_TOL) begin
        stol_r <= cfg_wdata[STOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    cur_int_r   <= cur_int_nxt;
    cur_slope_r <= cur_slope_nxt;
  end

endmodule
`default_nettype wire

@@ src/smpd_out_buf.sv @@
// Result output register with one holding stage behind it.
`default_nettype none
module smpd_out_buf (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   res_valid,
  input  wire smpd_pkg::smpd_result_t res,
  output logic                        buf_free,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output smpd_pkg::smpd_result_t      out_res
);
  import smpd_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         hold_valid_r, hold_valid_nxt;
  smpd_result_t out_r, out_nxt;
  smpd_result_t hold_r, hold_nxt;
  logic         room;

  assign room       = !out_valid_r || out_tready;
  assign buf_free   = !hold_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    hold_nxt       = hold_r;
    if (hold_valid_r) begin
      if (room) begin
        out_nxt        = hold_r;
        out_valid_nxt  = 1'b1;
        hold_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (room) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        hold_nxt       = res;
        hold_valid_nxt = 1'b1;
      end
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

endmodule
`default_nettype wire

@@ src/slope_match_period_detector.sv @@
// Top level of the slope-matching period detector.
//
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   tuser: mode, slope_class; tdata: slope_value
//  out_     master     out_tvalid/out_tready tuser: result_code; tdata: period, pin, det reset
//  cfg_     write      cfg_we                cfg_addr index, cfg_wdata value
//
// A tick, a first event or a class other than within tolerance is finished in the idle state. A later
// within-tolerance event reads window entry 0 and, on a match, sums the stored intervals one
// memory read a cycle through the single read port of the window store. One item is in work
// at a time; one finished result may wait in a holding stage while the output register
// is stalled. Reset is synchronous; the window store is not cleared.
`default_nettype none
module slope_match_period_detector #(
  parameter int WINDOW_DEPTH  = smpd_pkg::DEF_WINDOW_DEPTH,
  parameter int INTERVAL_BITS = smpd_pkg::DEF_INTERVAL_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [2:0]                      in_tuser,   // mode, slope_class[1:0]
  input  wire logic [7:0]                      in_tdata,   // slope_value[7:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [1:0]                           out_tuser,  // result_code[1:0]
  output logic [23:0]                          out_tdata,  // period_ticks[19:0], pin_pulse,
                                                           // detector_reset, 2 zero bits
  input  wire logic                            cfg_we,
  input  wire logic [smpd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [smpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import smpd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int MEM_W = INTERVAL_BITS + SLOPE_W;

  logic             mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
  logic [MEM_W-1:0] mem_wr_data, mem_rd_data;
  logic             buf_free, res_valid;
  smpd_result_t     res, out_res;

  smpd_window_ram #(
    .DEPTH  (WINDOW_DEPTH),
    .DATA_W (MEM_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  smpd_ctrl #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .buf_free    (buf_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  smpd_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .buf_free   (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tuser = out_res.code;
  assign out_tdata = {2'b00, out_res.det_rst, out_res.pin, out_res.period};

endmodule
`default_nettype wire

@@ test/tb_slope_match_period_detector.sv @@
// Testbench for slope_match_period_detector: directed and random items checked by a local predictor.
`timescale 1ns / 1ps

module tb_slope_match_period_detector;
  import smpd_pkg::*;

  localparam int WIN           = DEF_WINDOW_DEPTH;
  localparam int IBITS         = DEF_INTERVAL_BITS;
  localparam int SETTLE_CYCLES = DEF_WINDOW_DEPTH + 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int PHASE_ITEMS   = 90;

  localparam logic [CLASS_W-1:0] CLS_BELOW = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2:0]            in_tuser = '0;   // mode, slope_class[1:0]
  logic [7:0]            in_tdata = '0;   // slope_value[7:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [1:0]            out_tuser;       // result_code[1:0]
  logic [23:0]           out_tdata;       // period[19:0], pin, detector reset, 2 zero bits
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  slope_match_period_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [IBITS-1:0]    win_interval [WIN];
  logic [SLOPE_W-1:0]  win_slope [WIN];
  int unsigned         win_fill;
  int unsigned         miss_run;
  logic [IBITS-1:0]    tick_run;
  logic [PERIOD_W-1:0] period_hold;
  logic [ITOL_W-1:0]   interval_tol;
  logic [STOL_W-1:0]   slope_tol;

  smpd_result_t expected_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           src_idle_on = 1'b1;
  bit           sink_idle_on = 1'b1;
  bit           sink_hold_req = 1'b0;

  function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic smpd_result_t predict_result(input logic m, input logic [1:0] c,
                                                  input logic [7:0] s);
    smpd_result_t r;
    int unsigned  f;
    int unsigned  sum;
    r = '0;
    if (win_fill >= WIN) win_fill = 0;
    if (m == MODE_TICK) begin
      if (tick_run != '1) tick_run = tick_run + 1'b1;
    end else if (c == CLS_ABOVE) begin
      miss_run = 0;
      tick_run = '0;
      win_fill = 0;
      r.pin = 1'b1;
    end else if (c == CLS_WITHIN) begin
      f = win_fill;
      win_slope[f] = s;
      win_interval[f] = tick_run;
      tick_run = '0;
      if (f == 0) begin
        miss_run = 0;
        win_fill = 1;
        r.code = RES_INIT;
      end else if (abs_gap(win_interval[0], win_interval[f]) <= interval_tol &&
                   abs_gap(win_slope[0], s) <= slope_tol) begin
        sum = 0;
        miss_run = 0;
        for (int i = 0; i < f; i++) sum += win_interval[i];
        period_hold = (sum > PERIOD_MAX) ? PERIOD_MAX : sum[PERIOD_W-1:0];
        win_interval[0] = win_interval[f];
        win_slope[0] = win_slope[f];
        win_fill = 1;
        r.pin = 1'b1;
        r.code = RES_FOUND;
      end else begin
        win_fill = f + 1;
        if (win_fill >= WIN) begin
          win_fill = 0;
          tick_run = '0;
          miss_run = 0;
          r.det_rst = 1'b1;
        end
      end
    end else begin
      // below tolerance and the spare class both count as a miss
      miss_run++;
      if (miss_run >= WIN) begin
        win_fill = 0;
        tick_run = '0;
        miss_run = 0;
        r.det_rst = 1'b1;
      end
    end
    r.period = period_hold;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t: mismatch: %s", $time, what);
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic m, input logic [1:0] c, input logic [7:0] s);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {c, m};
    in_tdata  <= s;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(predict_result(m, c, s));
  endtask

  // tick items carry junk in the class and slope fields, which the block ignores
  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 2'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_INTERVAL_TOL) interval_tol = val;
    else slope_tol = val[STOL_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tolerances(input logic [ITOL_W-1:0] itol, input logic [STOL_W-1:0] stol);
    write_reg(REG_INTERVAL_TOL, itol);
    // upper byte is junk: only the low byte of the slope register is kept
    write_reg(REG_SLOPE_TOL, {8'($urandom), stol});
  endtask

  // mostly runs of matching events around a base interval and slope, plus noise
  task automatic run_random_items(input int count);
    int         sent;
    int         base_ticks;
    int         ticks;
    int         follow;
    int         r;
    logic [7:0] base_slope;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 1) == 1) begin
          send_item(MODE_EVENT, CLS_ABOVE, 8'($urandom));
          sent++;
        end
        base_ticks = $urandom_range(0, 30);
        base_slope = 8'($urandom);
        send_ticks(base_ticks);
        send_item(MODE_EVENT, CLS_WITHIN, base_slope);
        sent += base_ticks + 1;
        follow = $urandom_range(1, 6);
        repeat (follow) begin
          if (sent < count) begin
            ticks = base_ticks + int'($urandom_range(0, 24)) - 12;
            if (ticks < 0) ticks = 0;
            if ($urandom_range(0, 7) == 0) begin
              send_item(MODE_EVENT, $urandom_range(0, 1) ? CLS_BELOW : CLS_SPARE,
                        8'($urandom));
              sent++;
            end
            send_ticks(ticks);
            send_item(MODE_EVENT, CLS_WITHIN, 8'(base_slope + $urandom_range(0, 8) - 4));
            sent += ticks + 1;
          end
        end
      end else begin
        send_item(1'($urandom), 2'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_ticks(3);
    send_item(MODE_EVENT, CLS_WITHIN, 8'h00);   // first event
    send_ticks(5);
    send_item(MODE_EVENT, CLS_WITHIN, 8'h03);   // match with slope at the tolerance edge
    send_ticks(2);
    send_item(MODE_EVENT, CLS_BELOW, 8'h80);
    send_item(MODE_EVENT, CLS_SPARE, 8'h7F);
    send_item(MODE_EVENT, CLS_WITHIN, 8'hFF);   // slope too far off
    send_item(MODE_EVENT, CLS_WITHIN, 8'h03);   // match over two stored intervals
    send_item(MODE_EVENT, CLS_ABOVE, 8'hAA);
  endtask

  task automatic test_window_resets();
    send_item(MODE_EVENT, CLS_WITHIN, 8'h40);
    // misses fill the window
    for (int i = 0; i < WIN; i++)
      send_item(MODE_EVENT, (i % 2 == 0) ? CLS_BELOW : CLS_SPARE, 8'(i * 17));
    send_item(MODE_EVENT, CLS_WITHIN, 8'h10);
    // non-matching events fill the window
    repeat (WIN - 1) send_item(MODE_EVENT, CLS_WITHIN, 8'h90);
  endtask

  task automatic test_tolerance_extremes();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_ticks(60);
    send_item(MODE_EVENT, CLS_WITHIN, 8'h00);   // stored interval is a long count
    set_tolerances(16'hFFFF, STOL_RESET);
    send_ticks(1);
    send_item(MODE_EVENT, CLS_WITHIN, 8'h00);
    set_tolerances(16'hFFFF, 8'hFF);
    send_item(MODE_EVENT, CLS_WITHIN, 8'hFF);
  endtask

  task automatic test_random_phases();
    logic [ITOL_W-1:0] itol;
    logic [STOL_W-1:0] stol;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin itol = '0; stol = '0; end
        1: begin itol = '1; stol = '1; end
        2: begin itol = ITOL_RESET; stol = STOL_RESET; end
        3: begin itol = 16'($urandom); stol = 8'($urandom); end
        default: begin
          itol = 16'($urandom_range(0, 20));
          stol = 8'($urandom_range(0, 8));
        end
      endcase
      set_tolerances(itol, stol);
      src_idle_on  = (ph != 2);
      sink_idle_on = (ph != 3);
      run_random_items(PHASE_ITEMS);
    end
  endtask

  task automatic test_input_backpressure();
    src_idle_on   = 1'b0;
    sink_idle_on  = 1'b1;
    sink_hold_req = 1'b1;
    run_random_items(40);
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && sink_idle_on && $urandom_range(0, 2) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // sampled mid-cycle: the item moves at the next rising edge
  always @(negedge clk) begin : result_check
    smpd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.code)
          report_mismatch($sformatf("code %0d, want %0d", out_tuser, want.code));
        if (out_tdata[19:0] !== want.period)
          report_mismatch($sformatf("period %0d, want %0d", out_tdata[19:0], want.period));
        if (out_tdata[20] !== want.pin)
          report_mismatch($sformatf("pin %b, want %b", out_tdata[20], want.pin));
        if (out_tdata[21] !== want.det_rst)
          report_mismatch($sformatf("detector reset %b, want %b", out_tdata[21], want.det_rst));
        if (out_tdata[23:22] !== 2'b00)
          report_mismatch($sformatf("pad bits %b", out_tdata[23:22]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_slope_match_period_detector: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) begin
      win_interval[i] = '0;
      win_slope[i] = '0;
    end
    win_fill     = 0;
    miss_run     = 0;
    tick_run     = '0;
    period_hold  = '0;
    interval_tol = ITOL_RESET;
    slope_tol    = STOL_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_window_resets();
    test_tolerance_extremes();
    test_random_phases();
    test_input_backpressure();
    wait_drained();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_slope_match_period_detector: clean");
    end else begin
      $display("tb_slope_match_period_detector: errors");
    end
    $finish;
  end

endmodule
